@@ sv/spes_pkg.sv @@
`timescale 1ns / 1ps

package spes_pkg;

  // operation codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // cell command modes
  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_INS  = 2'd1;
  localparam logic [1:0] CM_DEL  = 2'd2;
  localparam logic [1:0] CM_SRCH = 2'd3;

  localparam int DEFAULT_DEPTH = 64;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic [6:0]         remove_count;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [6:0] fill_level;
  } result_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

@@ sv/spes_cell.sv @@
`timescale 1ns / 1ps

module spes_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  spes_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]         idx,
  input  logic [CW-1:0]         cnt,
  input  logic [31:0]           left_entry,
  input  logic [31:0]           right_entry,
  input  logic                  hit_in,
  output logic [31:0]           entry,
  output logic                  hit_out
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic hit;
  logic match;

  assign match   = (MY_IDX < cnt) && (entry == ctl.value);
  assign hit_out = hit;

  always_ff @(posedge clk) begin
    case (ctl.mode)
      spes_pkg::CM_INS: begin
        if (MY_IDX == idx) begin
          entry <= ctl.value;
        end else if (MY_IDX > idx) begin
          entry <= left_entry;
        end
      end
      spes_pkg::CM_DEL: begin
        if (MY_IDX >= idx) begin
          entry <= right_entry;
        end
      end
      spes_pkg::CM_SRCH: begin
        // hit flag ripples one cell per cycle toward the top end
        hit <= hit_in | match;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/stack_positional_edit_search.sv @@
`timescale 1ns / 1ps

// Bounded stack of signed 32-bit words with positional insert/delete and search.
// Input: a word on item is taken at a rising edge with start high and busy low.
// Output: each word yields exactly one result word on result, valid for the
//   single cycle in which done is high; the receiver cannot stall it.
// Storage is a row of STACK_DEPTH cells, cell 0 the bottom; each cell talks
//   only to its neighbors.
// Steps from the accept edge to the result:
//   rejected / empty / zero-count / unused code: done is registered at once
//   push, insert: one shift up of the row, in state S_INS
//   pop, delete of r entries: r single shifts down, in state S_DEL
//   search: hit flag ripples the whole row in S_SRCH, then S_SFIN issues it
// busy is high from the accept edge until the result is issued, so the
// insert shift, the delete shift count and the search ripple set the item rate.
// Reset (rst, synchronous) empties the stack and drops any work in flight;
// cell contents are not cleared, entries above the fill count are never read.
module stack_positional_edit_search #(
  parameter int STACK_DEPTH = spes_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spes_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output spes_pkg::result_t result
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int TW = $clog2(STACK_DEPTH);
  localparam int XW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SFIN = 3'd4;

  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [TW-1:0] LAST_T  = TW'(STACK_DEPTH - 1);
  localparam logic [XW-1:0] ONE_X   = XW'(1);

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] rem;
  logic [TW-1:0] timer;
  logic [31:0]   value;

  spes_pkg::cell_ctl_t ctl;

  logic [31:0] ent   [STACK_DEPTH];
  logic        hit   [STACK_DEPTH];

  // accept-time decode
  logic          accept;
  logic [XW-1:0] ne, pe, ke, del_p, del_k, sp1, r_x;
  logic [CW-1:0] ins_idx, del_start, del_r, del_lo;
  logic          full, empty;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign full   = (count >= DEPTH_C);
  assign empty  = (count == '0);

  always_comb begin
    ne    = XW'(count);
    pe    = XW'(item.position);
    ke    = XW'(item.remove_count);
    // position 1, 0 or above the top means "on top"
    ins_idx = (pe <= ONE_X || pe > ne) ? count : CW'(pe - ONE_X);
    // pop is a delete of one at the top
    del_p = (item.operation == spes_pkg::OP_POP) ? ONE_X : pe;
    del_k = (item.operation == spes_pkg::OP_POP) ? ONE_X : ke;
    del_start = (del_p <= ONE_X || del_p >= ne) ? (count - CW'(1)) : CW'(del_p - ONE_X);
    sp1   = XW'(del_start) + ONE_X;
    r_x   = (del_k > sp1) ? sp1 : del_k;
    del_r = CW'(r_x);
    del_lo = CW'(sp1 - r_x);
  end

  // command broadcast to the cell row
  always_comb begin
    ctl.value = value;
    case (state)
      S_INS:   ctl.mode = spes_pkg::CM_INS;
      S_DEL:   ctl.mode = spes_pkg::CM_DEL;
      S_SRCH:  ctl.mode = spes_pkg::CM_SRCH;
      default: ctl.mode = spes_pkg::CM_HOLD;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [31:0] left_e, right_e;
      logic        hit_l;
      if (gi == 0) begin : g_bot
        assign left_e = '0;
        assign hit_l  = 1'b0;
      end else begin : g_mid
        assign left_e = ent[gi-1];
        assign hit_l  = hit[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_top
        assign right_e = ent[gi];
      end else begin : g_below
        assign right_e = ent[gi+1];
      end
      spes_cell #(
        .CW  (CW),
        .IDX (gi)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .idx         (idx),
        .cnt         (count),
        .left_entry  (left_e),
        .right_entry (right_e),
        .hit_in      (hit_l),
        .entry       (ent[gi]),
        .hit_out     (hit[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            value             <= item.value;
            result.found      <= 1'b0;
            result.status     <= spes_pkg::STAT_DONE;
            result.fill_level <= 7'(count);
            case (item.operation)
              spes_pkg::OP_PUSH, spes_pkg::OP_INSERT: begin
                if (full) begin
                  result.status <= spes_pkg::STAT_FULL;
                  done          <= 1'b1;
                end else begin
                  idx   <= (item.operation == spes_pkg::OP_PUSH) ? count : ins_idx;
                  state <= S_INS;
                end
              end
              spes_pkg::OP_POP, spes_pkg::OP_DELETE: begin
                if (empty) begin
                  result.status <= spes_pkg::STAT_EMPTY;
                  done          <= 1'b1;
                end else if (del_r == '0) begin
                  done <= 1'b1;
                end else begin
                  idx   <= del_lo;
                  rem   <= del_r;
                  state <= S_DEL;
                end
              end
              spes_pkg::OP_SEARCH: begin
                timer <= '0;
                state <= S_SRCH;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_INS: begin
          count             <= count + CW'(1);
          result.fill_level <= 7'(count + CW'(1));
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_DEL: begin
          // one single-step shift down per cycle
          count <= count - CW'(1);
          rem   <= rem - CW'(1);
          if (rem == CW'(1)) begin
            result.fill_level <= 7'(count - CW'(1));
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_SRCH: begin
          timer <= timer + TW'(1);
          if (timer == LAST_T) begin
            state <= S_SFIN;
          end
        end
        S_SFIN: begin
          result.found <= hit[STACK_DEPTH-1];
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("fill count above depth");

  // a hit is only reported with a done status
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.status == spes_pkg::STAT_DONE))
    else $error("found with non-done status");

  // a full rejection happens only with the row full
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == spes_pkg::STAT_FULL) |-> (count == DEPTH_C))
    else $error("full status below depth");

  // delete shifting always has work left and entries to remove
  a_del_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) |-> (rem != '0 && count != '0))
    else $error("delete shift with nothing to remove");

endmodule

@@ test/tb_stack_positional_edit_search.sv @@
`timescale 1ns / 1ps

// Checks the bounded stack against a mirror of it kept here. A short scripted
// run covers the empty and unused-code cases, the value extremes and the
// position and count edge cases. Random phases follow; each phase leans
// toward growing, shrinking or mixed edits, so the fill level drifts toward the
// full limit and toward empty.
module tb_stack_positional_edit_search;

  localparam int DEPTH        = spes_pkg::DEFAULT_DEPTH;
  localparam int RANDOM_WORDS = 850;

  // codes the block must treat as no-ops
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef enum int {GROW, SHRINK, MIXED} lean_t;

  // one scripted word; 'pinned' rows carry a hand-written expected result
  typedef struct packed {
    spes_pkg::item_t   w;
    logic              pinned;
    spes_pkg::result_t want;
  } step_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              done;
  spes_pkg::item_t   item;
  spes_pkg::result_t result;

  stack_positional_edit_search dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // mirror of the stack, index 0 is the bottom
  logic [31:0] mirror [DEPTH];
  int          mirror_fill;

  spes_pkg::result_t pending [$];   // expected results, oldest first
  step_t             script [$];
  spes_pkg::result_t oldest;
  bit                pace_on;       // random gaps before each word when set

  int errors;
  int words_sent;
  int results_seen;
  int full_rejects;
  int empty_hits;
  int search_hits;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous cap: far above the slowest legal run (every word a full search)
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic note_error(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Applies one word to the mirror and returns the result the block must give.
  function automatic spes_pkg::result_t apply_word(input spes_pkg::item_t w);
    spes_pkg::result_t r;
    int          n;
    int          at;
    int          pos;
    int          cnt;
    int          i;
    r   = '0;
    r.status = spes_pkg::STAT_DONE;
    n   = mirror_fill;
    pos = int'(w.position);
    cnt = int'(w.remove_count);
    case (w.operation)
      spes_pkg::OP_PUSH, spes_pkg::OP_INSERT: begin
        if (n >= DEPTH) begin
          r.status = spes_pkg::STAT_FULL;
        end else begin
          // position 0/1 or beyond the top lands on top
          if (w.operation == spes_pkg::OP_PUSH || pos <= 1 || pos > n) at = n;
          else at = pos - 1;
          for (i = n; i > at; i--) mirror[i] = mirror[i - 1];
          mirror[at] = w.value;
          mirror_fill = n + 1;
        end
      end
      spes_pkg::OP_POP, spes_pkg::OP_DELETE: begin
        if (w.operation == spes_pkg::OP_POP) begin
          pos = 1;
          cnt = 1;
        end
        if (n == 0) begin
          r.status = spes_pkg::STAT_EMPTY;
        end else begin
          // start at the top unless the position is strictly inside
          if (pos <= 1 || pos >= n) at = n - 1;
          else at = pos - 1;
          // removal runs downward and stops at the bottom
          if (cnt > at + 1) cnt = at + 1;
          for (i = at + 1; i < n; i++) mirror[i - cnt] = mirror[i];
          mirror_fill = n - cnt;
        end
      end
      spes_pkg::OP_SEARCH: begin
        for (i = 0; i < n; i++)
          if (mirror[i] == w.value) r.found = 1'b1;
      end
      default: ;
    endcase
    r.fill_level = 7'(mirror_fill);
    return r;
  endfunction

  function automatic step_t mk(input logic [2:0] op, input logic [31:0] value,
                               input int pos, input int cnt, input logic pinned,
                               input logic [1:0] st, input logic fd, input int fl);
    step_t s;
    s.w.operation    = op;
    s.w.value        = value;
    s.w.position     = 7'(pos);
    s.w.remove_count = 7'(cnt);
    s.pinned         = pinned;
    s.want.status    = st;
    s.want.found     = fd;
    s.want.fill_level = 7'(fl);
    return s;
  endfunction

  // Random word; the lean sets the operation mix so the fill level drifts.
  function automatic spes_pkg::item_t random_word(input lean_t lean);
    spes_pkg::item_t w;
    int unsigned roll;
    int unsigned c_push, c_ins, c_srch, c_pop, c_del;
    case (lean)
      GROW:    begin c_push = 35; c_ins = 65; c_srch = 80; c_pop = 88; c_del = 95; end
      SHRINK:  begin c_push = 15; c_ins = 25; c_srch = 40; c_pop = 65; c_del = 93; end
      default: begin c_push = 20; c_ins = 40; c_srch = 60; c_pop = 75; c_del = 96; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < c_push)      w.operation = spes_pkg::OP_PUSH;
    else if (roll < c_ins)  w.operation = spes_pkg::OP_INSERT;
    else if (roll < c_srch) w.operation = spes_pkg::OP_SEARCH;
    else if (roll < c_pop)  w.operation = spes_pkg::OP_POP;
    else if (roll < c_del)  w.operation = spes_pkg::OP_DELETE;
    else                    w.operation = 3'(OP_SPARE5 + $urandom_range(0, 2));

    // values: often ones already stored, so searches hit and duplicates form
    roll = $urandom_range(0, 99);
    if (roll < 30 && mirror_fill > 0)
      w.value = mirror[$urandom_range(0, mirror_fill - 1)];
    else if (roll < 55)
      w.value = int'($urandom_range(0, 8)) - 4;
    else if (roll < 65)
      case ($urandom_range(0, 3))
        0:       w.value = 32'h8000_0000;
        1:       w.value = 32'h7FFF_FFFF;
        2:       w.value = 32'hFFFF_FFFF;
        default: w.value = 32'h0;
      endcase
    else
      w.value = $urandom;

    roll = $urandom_range(0, 99);
    if (roll < 50)
      w.position = 7'($urandom_range(0, mirror_fill + 1));
    else if (roll < 75)
      w.position = 7'($urandom_range(0, 127));
    else
      case ($urandom_range(0, 3))
        0:       w.position = 7'd1;
        1:       w.position = 7'(mirror_fill);
        2:       w.position = 7'(mirror_fill - 1);
        default: w.position = 7'd65;
      endcase

    roll = $urandom_range(0, 99);
    if (lean == GROW)  w.remove_count = 7'($urandom_range(0, 2));
    else if (roll < 60) w.remove_count = 7'($urandom_range(0, 4));
    else if (roll < 85) w.remove_count = 7'($urandom_range(0, 127));
    else                w.remove_count = 7'($urandom_range(DEPTH, 127));
    return w;
  endfunction

  // Drives one word from a falling edge and returns at the falling edge after
  // it was taken. start stays high between back-to-back words.
  task automatic issue(input spes_pkg::item_t w, input logic pinned,
                       input spes_pkg::result_t want);
    int                gap;
    spes_pkg::result_t got_pred;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item  <= w;
    start <= 1'b1;
    // taken at the first rising edge that sees busy low
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    got_pred = apply_word(w);
    pending.push_back(pinned ? want : got_pred);
    words_sent++;
    if (got_pred.status == spes_pkg::STAT_FULL)  full_rejects++;
    if (got_pred.status == spes_pkg::STAT_EMPTY) empty_hits++;
    if (got_pred.found)                          search_hits++;
    @(negedge clk);
  endtask

  // Result checker: done marks a single-cycle result word, no back-pressure.
  always @(posedge clk) begin
    if (!rst && $isunknown(done)) begin
      note_error("done is unknown");
    end else if (!rst && done) begin
      results_seen++;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result %p", result));
      end else begin
        oldest = pending.pop_front();
        if (result.status !== oldest.status)
          note_error($sformatf("status %0d, want %0d", result.status, oldest.status));
        if (result.found !== oldest.found)
          note_error($sformatf("found %0b, want %0b", result.found, oldest.found));
        if (result.fill_level !== oldest.fill_level)
          note_error($sformatf("fill_level %0d, want %0d",
                               result.fill_level, oldest.fill_level));
      end
    end
  end

  initial begin
    lean_t lean;
    int    span;
    int    sent;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    full_rejects = 0;
    empty_hits = 0;
    search_hits = 0;
    mirror_fill = 0;
    pace_on = 1'b1;

    // scripted words; the stack starts empty
    // removals and search on an empty stack
    script.push_back(mk(spes_pkg::OP_POP, 32'h0, 1, 1, 1'b1,
                        spes_pkg::STAT_EMPTY, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 1, 5, 1'b1,
                        spes_pkg::STAT_EMPTY, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 3, 0, 1'b1,
                        spes_pkg::STAT_EMPTY, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_SEARCH, 32'h0, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 0));
    script.push_back(mk(OP_SPARE5, 32'hFFFF_FFFF, 127, 127, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 0));
    // value extremes
    script.push_back(mk(spes_pkg::OP_PUSH, 32'h8000_0000, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 1));
    script.push_back(mk(spes_pkg::OP_PUSH, 32'h7FFF_FFFF, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 2));
    // insert: position 0 means top, inside, far above the top, just inside
    script.push_back(mk(spes_pkg::OP_INSERT, 32'hFFFF_FFFF, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 3));
    script.push_back(mk(spes_pkg::OP_INSERT, 32'h0,    2,   0, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_INSERT, 32'h5,    127, 0, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_INSERT, 32'h1234, 4,   0, 1'b0, '0, 1'b0, 0));
    // search hits at both extremes and a miss
    script.push_back(mk(spes_pkg::OP_SEARCH, 32'h8000_0000, 0, 0, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_SEARCH, 32'h7FFF_FFFF, 0, 0, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_SEARCH, 32'h0001_2345, 0, 0, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(OP_SPARE6, 32'h0, 0, 0, 1'b1, spes_pkg::STAT_DONE, 1'b0, 6));
    script.push_back(mk(OP_SPARE7, 32'h0, 0, 0, 1'b1, spes_pkg::STAT_DONE, 1'b0, 6));
    // delete: zero count, inside run, count past the bottom, position past top
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 3, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 6));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 3,  2,   1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 2,  127, 1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 65, 1,   1'b0, '0, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_POP, 32'h0, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_POP, 32'h0, 0, 0, 1'b1,
                        spes_pkg::STAT_EMPTY, 1'b0, 0));
    script.push_back(mk(spes_pkg::OP_PUSH, 32'h0, 0, 0, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 1));
    script.push_back(mk(spes_pkg::OP_DELETE, 32'h0, 1, 64, 1'b1,
                        spes_pkg::STAT_DONE, 1'b0, 0));

    // synchronous reset, released on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i])
      issue(script[i].w, script[i].pinned, script[i].want);

    // random phases; the first one leans toward growth for 150 words
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent == 0) begin
        lean = GROW;
        span = 150;
      end else begin
        lean = lean_t'($urandom_range(0, 2));
        span = $urandom_range(40, 120);
      end
      pace_on = ($urandom_range(0, 3) != 0);
      repeat (span) begin
        issue(random_word(lean), 1'b0, '0);
        sent++;
      end
    end
    start <= 1'b0;

    // drain, then watch a full search latency for stray results
    while (pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Ran %0d words, %0d results checked: %0d full rejects, %0d empty removals,",
             words_sent, results_seen, full_rejects, empty_hits);
    $display("%0d search hits; stack filled and drained across random phases.",
             search_hits);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/spes_pkg.sv
sv/spes_cell.sv
sv/stack_positional_edit_search.sv
test/tb_stack_positional_edit_search.sv
